>>> rtl/fhw_pkg.sv
// Shared types and constants for the frame window access unit.
`default_nettype none
package fhw_pkg;

    localparam int STORE_ADDR_W = 20;
    localparam int JOB_DEPTH    = 2;

    typedef enum logic [2:0] {
        CMD_FRAME_RD = 3'd0,
        CMD_FRAME_WR = 3'd1,
        CMD_BANK_RD  = 3'd2,
        CMD_BANK_WR  = 3'd3,
        CMD_CTRL_RD  = 3'd4,
        CMD_CTRL_WR  = 3'd5
    } t_cmd;

    // control register select, offset low nibble
    localparam logic [3:0] CTRL_BCAST = 4'h4;
    localparam logic [3:0] CTRL_ILV   = 4'h5;
    localparam logic [3:0] CTRL_OVL   = 4'h6;
    localparam logic [3:0] CTRL_DIR   = 4'hf;

    typedef enum logic [1:0] {
        JOB_RD,
        JOB_WR,
        JOB_IMM
    } t_job_op;

    typedef struct packed {
        t_job_op                 op;
        logic                    bcast;
        logic [STORE_ADDR_W-1:0] addr;
        logic [7:0]              data;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_BCAST,
        BK_RDATA
    } t_bk_state;

    localparam logic [1:0] BCAST_LAST = 2'd2;

endpackage
`default_nettype wire

>>> rtl/fhw_front.sv
// Front end: owns bank/mode/large-mode registers and turns bus beats into store jobs.
`default_nettype none
module fhw_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [2:0]    i_cmd,
    input  logic [15:0]   i_offset,
    input  logic [7:0]    i_wdata,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_large_mode,
    input  logic          i_q_full,
    output logic          o_q_push,
    output fhw_pkg::t_job o_job
);
    import fhw_pkg::*;

    logic [3:0] r_bank;
    logic [3:0] r_mode;
    logic       r_large;
    logic [3:0] n_bank;
    logic [3:0] n_mode;

    logic                    accept;
    logic [3:0]              ctrl_bit;
    logic [STORE_ADDR_W-1:0] lin_addr;
    logic [STORE_ADDR_W-1:0] dir_addr;
    logic [STORE_ADDR_W-1:0] ilv_addr;
    t_job                    job;

    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept;
    assign o_job    = job;

    assign lin_addr = {r_bank, i_offset};
    assign dir_addr = {2'b00, r_mode[3:2], i_offset};
    assign ilv_addr = {i_offset[1:0], r_bank, i_offset[15:2]};

    always_comb begin
        unique case (i_offset[3:0])
            CTRL_BCAST: ctrl_bit = 4'b0010;
            CTRL_ILV:   ctrl_bit = 4'b0100;
            CTRL_OVL:   ctrl_bit = 4'b1000;
            CTRL_DIR:   ctrl_bit = 4'b0001;
            default:    ctrl_bit = 4'b0000;
        endcase
    end

    always_comb begin
        job        = '0;
        job.op     = JOB_IMM;
        job.data   = i_wdata;
        n_bank     = r_bank;
        n_mode     = r_mode;
        unique case (i_cmd)
            CMD_FRAME_RD: begin
                job.op = JOB_RD;
                priority if (r_mode[0] && !r_large) begin
                    job.addr = dir_addr;
                end else if (r_mode[2] && !r_large) begin
                    job.addr = ilv_addr;
                end else begin
                    job.addr = lin_addr;
                end
            end
            CMD_FRAME_WR: begin
                job.op = JOB_WR;
                priority if (r_large || r_mode[2:1] == 2'b00) begin
                    job.addr = lin_addr;
                end else if (r_mode[0]) begin
                    job.addr  = dir_addr;
                    job.bcast = 1'b1;
                end else if (r_mode[2:1] == 2'b01) begin
                    if (r_bank >= 4'd12) begin
                        job.addr = lin_addr;
                    end else begin
                        job.addr  = {2'b00, r_bank[1:0], i_offset};
                        job.bcast = 1'b1;
                    end
                end else if (ilv_addr[STORE_ADDR_W-1 -: 2] == 2'b11
                             && r_mode[2:1] == 2'b11) begin
                    job.op   = JOB_IMM;
                    job.data = 8'd0;
                end else begin
                    job.addr = ilv_addr;
                end
            end
            CMD_BANK_RD: begin
                job.data = {4'd0, r_bank};
            end
            CMD_BANK_WR: begin
                job.data = 8'd0;
                n_bank   = i_wdata[3:0];
            end
            CMD_CTRL_RD: begin
                job.data = ((r_mode & ctrl_bit) != 4'd0) ? 8'hff : 8'h00;
            end
            CMD_CTRL_WR: begin
                job.data = 8'd0;
                n_mode   = i_wdata[7] ? (r_mode | ctrl_bit) : (r_mode & ~ctrl_bit);
            end
            default: begin
                job.data = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= '0;
            r_mode  <= '0;
            r_large <= 1'b0;
        end else begin
            if (accept) begin
                r_bank <= n_bank;
                r_mode <= n_mode;
            end
            if (i_cfg_valid) begin
                r_large <= i_cfg_large_mode;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/fhw_job_queue.sv
// Small job queue between front end and store sequencer.
`default_nettype none
module fhw_job_queue #(
    parameter int DEPTH = fhw_pkg::JOB_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fhw_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output fhw_pkg::t_job o_job
);
    import fhw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/fhw_back.sv
// Back end: frame store, job sequencer and result register.
`default_nettype none
module fhw_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  fhw_pkg::t_job i_job,
    output logic          o_q_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_rdata
);
    import fhw_pkg::*;

    localparam int STORE_BYTES = 2 ** STORE_ADDR_W;

    logic [7:0] r_store [STORE_BYTES];
    logic [7:0] r_mem_q;

    t_bk_state r_state;
    t_bk_state n_state;
    t_job      r_job;
    logic [1:0] r_step;
    logic       r_out_valid;
    logic [7:0] r_out_data;

    logic                    out_free;
    logic                    start;
    logic                    mem_we;
    logic [STORE_ADDR_W-1:0] mem_addr;
    logic [7:0]              mem_wdata;
    logic                    out_load;
    logic [7:0]              out_data;

    assign out_free = !r_out_valid || i_pop;
    assign start    = (r_state == BK_IDLE) && i_q_valid && out_free;
    assign o_empty  = !r_out_valid;
    assign o_rdata  = r_out_data;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (start && i_job.op == JOB_RD) begin
                    n_state = BK_RDATA;
                end else if (start && i_job.op == JOB_WR && i_job.bcast) begin
                    n_state = BK_BCAST;
                end
            end
            BK_BCAST: begin
                if (r_step == BCAST_LAST) begin
                    n_state = BK_IDLE;
                end
            end
            BK_RDATA: n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop   = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = i_job.addr;
        mem_wdata = i_job.data;
        out_load  = 1'b0;
        out_data  = 8'd0;
        unique case (r_state)
            BK_IDLE: begin
                if (start) begin
                    o_q_pop = 1'b1;
                    unique case (i_job.op)
                        JOB_RD: ;
                        JOB_WR: begin
                            mem_we   = 1'b1;
                            out_load = !i_job.bcast;
                        end
                        default: begin
                            out_load = 1'b1;
                            out_data = i_job.data;
                        end
                    endcase
                end
            end
            BK_BCAST: begin
                mem_we    = 1'b1;
                mem_addr  = {r_job.addr[STORE_ADDR_W-1 -: 2] + r_step,
                             r_job.addr[STORE_ADDR_W-3:0]};
                mem_wdata = r_job.data;
                out_load  = (r_step == BCAST_LAST);
            end
            BK_RDATA: begin
                out_load = 1'b1;
                out_data = r_mem_q;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_addr] <= mem_wdata;
        end
        r_mem_q <= r_store[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_job;
        end
        if (out_load) begin
            r_out_data <= out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (r_state == BK_BCAST) ? r_step + 2'd1 : 2'd1;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/framebuffer_host_window_access_unit.sv
// Top level of the host window access unit for the 1 MB frame store.
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+-------------------------
//  access in | i_cmd, i_offset, i_wdata               | push / full
//  result    | o_rdata                                | empty / pop
//  config    | i_cfg_large_mode                       | i_cfg_valid / o_cfg_ready
//
// Register and dropped-write beats are done in the sequencer's idle state; frame
// reads go on to BK_RDATA for the store read port; broadcast writes make one
// store write per plane, in idle then BK_BCAST. The Q_DEPTH-entry job queue
// lets the front take beats while the sequencer or result register waits for pop.
// Synchronous active-low reset clears control registers and queues, not store.
`default_nettype none
module framebuffer_host_window_access_unit #(
    parameter int Q_DEPTH = fhw_pkg::JOB_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_offset,
    input  logic [7:0]  i_wdata,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_rdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_large_mode
);
    import fhw_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job fe_job;
    t_job q_job;

    assign o_cfg_ready = 1'b1;

    fhw_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_cmd            (i_cmd),
        .i_offset         (i_offset),
        .i_wdata          (i_wdata),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_large_mode (i_cfg_large_mode),
        .i_q_full         (full),
        .o_q_push         (q_push),
        .o_job            (fe_job)
    );

    fhw_job_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (fe_job),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    fhw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (q_job),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_rdata   (o_rdata)
    );

endmodule
`default_nettype wire

>>> rtl/fhw_checker.sv
// Port-level checker for the host window access unit, bound to the top level.
`default_nettype none
module fhw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_rdata
);
    logic [7:0] r_pending;
    logic       acc_in;
    logic       acc_out;

    assign acc_in  = push && !full;
    assign acc_out = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {7'd0, acc_in} - {7'd0, acc_out};
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 8'd0 |-> empty)
        else $error("result beat with no access outstanding");

    a_not_full_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 8'd0 |-> !full)
        else $error("full with nothing outstanding");

    a_rdata_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_rdata))
        else $error("waiting result changed");

endmodule

bind framebuffer_host_window_access_unit fhw_checker u_fhw_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_rdata (o_rdata)
);
`default_nettype wire
